// File: hdl/i2crl_pkg.sv
// Shared types, codes and helper functions for the I2C register reader.
`timescale 1ns / 1ps

package i2crl_pkg;

    // Input op codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_READ2 = 3'd3;
    localparam logic [2:0] OP_LUX   = 3'd4;

    // Bus segment codes
    localparam logic [3:0] SEG_START  = 4'd0;
    localparam logic [3:0] SEG_ADDR_W = 4'd1;
    localparam logic [3:0] SEG_REG1   = 4'd2;
    localparam logic [3:0] SEG_DATA   = 4'd3;
    localparam logic [3:0] SEG_ADDR_R = 4'd4;
    localparam logic [3:0] SEG_RECV1  = 4'd5;
    localparam logic [3:0] SEG_REG2   = 4'd6;
    localparam logic [3:0] SEG_RECV2  = 4'd7;
    localparam logic [3:0] SEG_STOP   = 4'd8;

    localparam logic [5:0] STEP_IDLE    = 6'd63;
    localparam logic [7:0] DEV_ADDR_RST = 8'd148;
    localparam logic [7:0] LUX_REG_EXP  = 8'h03;
    localparam logic [7:0] LUX_REG_MANT = 8'h04;
    localparam logic [3:0] LUX_EXP_MAX  = 4'hE;
    localparam int         LUX_W        = 28;

    // One classified input transaction
    typedef struct packed {
        logic       cmd;
        logic [2:0] kind;
        logic [7:0] reg1;
        logic [7:0] reg2;
        logic [7:0] wdata;
        logic       sda;
    } t_item;

    // Number of segments in the sequence of a transaction kind
    function automatic logic [5:0] seg_count(input logic [2:0] kind);
        logic [5:0] c;
        case (kind)
            OP_WRITE: c = 6'd5;
            OP_READ:  c = 6'd7;
            default:  c = 6'd13;
        endcase
        return c;
    endfunction

    // Segment code at a given step of a transaction kind
    function automatic logic [3:0] seg_of(input logic [2:0] kind, input logic [3:0] step);
        logic [3:0] s;
        s = SEG_START;
        case (kind)
            OP_WRITE: begin
                case (step)
                    4'd1:    s = SEG_ADDR_W;
                    4'd2:    s = SEG_REG1;
                    4'd3:    s = SEG_DATA;
                    4'd4:    s = SEG_STOP;
                    default: s = SEG_START;
                endcase
            end
            OP_READ: begin
                case (step)
                    4'd1:    s = SEG_ADDR_W;
                    4'd2:    s = SEG_REG1;
                    4'd4:    s = SEG_ADDR_R;
                    4'd5:    s = SEG_RECV1;
                    4'd6:    s = SEG_STOP;
                    default: s = SEG_START;
                endcase
            end
            default: begin
                case (step)
                    4'd1:    s = SEG_ADDR_W;
                    4'd2:    s = SEG_REG1;
                    4'd4:    s = SEG_ADDR_R;
                    4'd5:    s = SEG_RECV1;
                    4'd7:    s = SEG_ADDR_W;
                    4'd8:    s = SEG_REG2;
                    4'd10:   s = SEG_ADDR_R;
                    4'd11:   s = SEG_RECV2;
                    4'd12:   s = SEG_STOP;
                    default: s = SEG_START;
                endcase
            end
        endcase
        return s;
    endfunction

    // Light conversion: (mantissa << exponent) * 63
    function automatic logic [LUX_W-1:0] lux_of(input logic [7:0] first,
                                                  input logic [7:0] second);
        logic [3:0]       ex;
        logic [21:0]      m;
        logic [LUX_W-1:0] r;
        ex = first[7:4];
        if (ex == 4'd1) begin
            ex = 4'd0;
        end else if (ex > LUX_EXP_MAX) begin
            ex = LUX_EXP_MAX;
        end
        m = {14'd0, first[3:0], second[3:0]} << ex;
        r = {m, 6'd0} - {6'd0, m};
        return r;
    endfunction

endpackage

// File: hdl/i2c_register_reader_with_lux_convert.sv
// Top level of the I2C register reader with light conversion.
//
// Input channel (i_valid / o_stall): one transaction is a tick that runs one
// bus phase, or a command (write reg, read reg, read two regs, read lux) that
// starts a bus sequence. A command seen while a sequence runs is rejected.
// Output channel (o_valid / i_stall): exactly one result per input
// transaction, carrying the SCL/SDA levels after that phase plus status,
// read bytes, NACK count and the converted light value.
// Configuration: i_cfg_we / i_cfg_data write the device address byte; write
// it only while no transaction is in flight.
// Throughput is one transaction per clock while the result is not stalled:
// a two-entry queue sits between the classifier and the sequencer, and the
// sequencer does one phase per clock into a result register that loads
// whenever it is empty or taken. Inputs pass a queue entry, then the result
// register. When i_stall holds, the result register keeps its value, the
// queue fills, and o_stall rises once both entries are occupied.
// Reset (synchronous, active low) empties the queue and result stage,
// returns the sequencer to idle with both lines released and restores the
// device address byte to its default.
`timescale 1ns / 1ps

module i2c_register_reader_with_lux_convert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_op,
    input  logic [7:0]                  i_reg_addr,
    input  logic [7:0]                  i_reg_addr_second,
    input  logic [7:0]                  i_write_data,
    input  logic                        i_sda_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_scl_level,
    output logic                        o_sda_release,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_rejected,
    output logic [7:0]                  o_read_first,
    output logic [7:0]                  o_read_second,
    output logic [2:0]                  o_nack_count,
    output logic [i2crl_pkg::LUX_W-1:0] o_lux_value
);
    import i2crl_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    assign o_stall = q_full;

    i2crl_front u_front (
        .i_op              (i_op),
        .i_reg_addr        (i_reg_addr),
        .i_reg_addr_second (i_reg_addr_second),
        .i_write_data      (i_write_data),
        .i_sda_in          (i_sda_in),
        .o_item            (front_item)
    );

    i2crl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    i2crl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_level   (o_scl_level),
        .o_sda_release (o_sda_release),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rejected    (o_rejected),
        .o_read_first  (o_read_first),
        .o_read_second (o_read_second),
        .o_nack_count  (o_nack_count),
        .o_lux_value   (o_lux_value)
    );

endmodule

// File: hdl/i2crl_front.sv
// Front end: classifies an incoming item as command or tick.
`timescale 1ns / 1ps

module i2crl_front (
    input  logic [2:0]      i_op,
    input  logic [7:0]      i_reg_addr,
    input  logic [7:0]      i_reg_addr_second,
    input  logic [7:0]      i_write_data,
    input  logic            i_sda_in,
    output i2crl_pkg::t_item o_item
);
    import i2crl_pkg::*;

    // Decode op; light read forces its fixed register pair
    always_comb begin
        o_item.kind  = i_op;
        o_item.reg1  = i_reg_addr;
        o_item.reg2  = i_reg_addr_second;
        o_item.wdata = i_write_data;
        o_item.sda   = i_sda_in;
        unique case (i_op) inside
            OP_WRITE, OP_READ, OP_READ2: begin
                o_item.cmd = 1'b1;
            end
            OP_LUX: begin
                o_item.cmd  = 1'b1;
                o_item.reg1 = LUX_REG_EXP;
                o_item.reg2 = LUX_REG_MANT;
            end
            default: begin
                o_item.cmd  = 1'b0;
                o_item.kind = OP_TICK;
            end
        endcase
    end

endmodule

// File: hdl/i2crl_queue.sv
// Two-entry queue between the front end and the bus sequencer.
`timescale 1ns / 1ps

module i2crl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2crl_pkg::t_item i_item,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output i2crl_pkg::t_item o_item
);
    import i2crl_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/i2crl_back.sv
// Back end: bus phase sequencer and registered result stage.
`timescale 1ns / 1ps

module i2crl_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_data,
    input  logic                        i_q_valid,
    input  i2crl_pkg::t_item            i_q_item,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_scl_level,
    output logic                        o_sda_release,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_rejected,
    output logic [7:0]                  o_read_first,
    output logic [7:0]                  o_read_second,
    output logic [2:0]                  o_nack_count,
    output logic [i2crl_pkg::LUX_W-1:0] o_lux_value
);
    import i2crl_pkg::*;

    // Sequencer state
    logic [7:0]  r_dev;
    logic [5:0]  r_step,  n_step;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_bit,   n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_kind,  n_kind;
    logic [23:0] r_held,  n_held;
    logic [15:0] r_rx,    n_rx;
    logic [2:0]  r_nack,  n_nack;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        n_done;
    logic        n_rej;

    // Result stage
    logic        r_out_valid;
    logic        r_out_scl;
    logic        r_out_sda;
    logic        r_out_busy;
    logic        r_out_done;
    logic        r_out_rej;
    logic [15:0] r_out_rx;
    logic [2:0]  r_out_nack;
    logic        r_out_lux;

    logic        out_ready;
    logic        step_en;

    assign out_ready = !r_out_valid || !i_stall;
    assign step_en   = i_q_valid && out_ready;
    assign o_q_pop   = step_en;

    // One bus phase per tick; a command starts a sequence or is rejected
    always_comb begin
        logic       busy;
        logic [5:0] cnt;
        logic [5:0] step_inc;
        logic [3:0] seg;
        logic       recv;
        logic [7:0] src;
        logic [7:0] sh;
        n_step  = r_step;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_kind  = r_kind;
        n_held  = r_held;
        n_rx    = r_rx;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        busy     = (r_step != STEP_IDLE);
        cnt      = seg_count(r_kind);
        step_inc = r_step + 6'd1;
        seg      = seg_of(r_kind, r_step[3:0]);
        recv     = (seg == SEG_RECV1) || (seg == SEG_RECV2);
        case (seg)
            SEG_ADDR_W: src = r_dev;
            SEG_ADDR_R: src = r_dev + 8'd1;
            SEG_REG1:   src = r_held[7:0];
            SEG_REG2:   src = r_held[15:8];
            default:    src = r_held[23:16];
        endcase
        sh = r_shift;

        if (i_q_item.cmd) begin
            if (busy) begin
                n_rej = 1'b1;
            end else begin
                n_kind  = i_q_item.kind;
                n_held  = {i_q_item.wdata, i_q_item.reg2, i_q_item.reg1};
                n_rx    = 16'd0;
                n_nack  = 3'd0;
                n_step  = 6'd0;
                n_bit   = 4'd0;
                n_phase = 2'd0;
                n_shift = 8'd0;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        end else if (!busy) begin
            n_scl = 1'b1;
            n_sda = 1'b1;
        end else if (r_step >= cnt) begin
            n_step = STEP_IDLE;
            n_scl  = 1'b1;
            n_sda  = 1'b1;
        end else begin
            unique case (seg)
                SEG_START: begin
                    n_scl = (r_phase == 2'd1) || (r_phase == 2'd2);
                    n_sda = (r_phase <= 2'd1);
                    if (r_phase == 2'd3) begin
                        n_step  = (step_inc >= cnt) ? STEP_IDLE : step_inc;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                SEG_STOP: begin
                    n_scl = (r_phase >= 2'd1);
                    n_sda = (r_phase >= 2'd2);
                    if (r_phase >= 2'd2) begin
                        n_step  = STEP_IDLE;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                default: begin
                    // Byte slot: load shifter on the first phase of bit one
                    if (r_bit == 4'd0 && r_phase == 2'd0) begin
                        sh = recv ? 8'd0 : src;
                    end
                    n_shift = sh;
                    n_scl   = (r_phase != 2'd0);
                    n_sda   = (r_bit < 4'd8 && !recv) ? sh[7] : 1'b1;
                    if (r_phase < 2'd2) begin
                        n_phase = r_phase + 2'd1;
                    end else if (r_bit < 4'd8) begin
                        n_shift = {sh[6:0], recv ? i_q_item.sda : 1'b0};
                        n_bit   = r_bit + 4'd1;
                        n_phase = 2'd0;
                    end else begin
                        if (seg == SEG_RECV1) begin
                            n_rx[7:0] = sh;
                        end else if (seg == SEG_RECV2) begin
                            n_rx[15:8] = sh;
                        end else if (i_q_item.sda && r_nack != 3'd7) begin
                            n_nack = r_nack + 3'd1;
                        end
                        n_step  = (step_inc >= cnt) ? STEP_IDLE : step_inc;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                    end
                end
            endcase
        end
    end

    // Sequencer and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= DEV_ADDR_RST;
            r_step  <= STEP_IDLE;
            r_phase <= 2'd0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_kind  <= OP_TICK;
            r_held  <= 24'd0;
            r_rx    <= 16'd0;
            r_nack  <= 3'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_dev <= i_cfg_data;
            end
            if (step_en) begin
                r_step  <= n_step;
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_kind  <= n_kind;
                r_held  <= n_held;
                r_rx    <= n_rx;
                r_nack  <= n_nack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
        end
    end

    // Result register; loads whenever it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_scl  <= n_scl;
            r_out_sda  <= n_sda;
            r_out_busy <= (n_step != STEP_IDLE);
            r_out_done <= n_done;
            r_out_rej  <= n_rej;
            r_out_rx   <= n_rx;
            r_out_nack <= n_nack;
            r_out_lux  <= (n_kind == OP_LUX);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_scl_level   = r_out_scl;
    assign o_sda_release = r_out_sda;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_rejected    = r_out_rej;
    assign o_read_first  = r_out_rx[7:0];
    assign o_read_second = r_out_rx[15:8];
    assign o_nack_count  = r_out_nack;
    assign o_lux_value   = r_out_lux ? lux_of(r_out_rx[7:0], r_out_rx[15:8]) : '0;

endmodule

// File: hdl/i2crl_checker.sv
// Port-level checks on the I2C register reader, bound to the top level.
`timescale 1ns / 1ps

module i2crl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_scl_level,
    input logic                        o_sda_release,
    input logic                        o_busy_res,
    input logic                        o_done_res,
    input logic                        o_rejected,
    input logic [2:0]                  o_nack_count,
    input logic [i2crl_pkg::LUX_W-1:0] o_lux_value
);
    // Idle results always show both lines released
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (o_scl_level && o_sda_release))
        else $error("idle result with a line driven low");

    // A finished stop leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (!o_busy_res && !o_rejected))
        else $error("done reported while still busy or rejecting");

    // Rejection only happens while a sequence runs
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> o_busy_res)
        else $error("command rejected while idle");

    // At most six sent bytes per sequence
    a_nack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nack_count != 3'd7))
        else $error("NACK count out of range");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_lux_value)
                                  && $stable(o_scl_level) && $stable(o_sda_release)))
        else $error("stalled result changed");

endmodule

bind i2c_register_reader_with_lux_convert i2crl_checker u_i2crl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_scl_level   (o_scl_level),
    .o_sda_release (o_sda_release),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_rejected    (o_rejected),
    .o_nack_count  (o_nack_count),
    .o_lux_value   (o_lux_value)
);

// File: tb/testbench.sv
// Self-checking testbench for the I2C register reader with light conversion.
`timescale 1ns / 1ps

module testbench;
    import i2crl_pkg::*;

    localparam logic [31:0] LUX_SCALE = 32'd63;
    localparam int          PHASE_QUOTA = 1;

    // Op codes with no command meaning; they act as ticks
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Segment order per transaction kind, step 0 in the low nibble
    localparam logic [63:0] WRITE_SEQ = {44'd0, SEG_STOP, SEG_DATA, SEG_REG1, SEG_ADDR_W,
                                         SEG_START};
    localparam logic [63:0] READ_SEQ  = {36'd0, SEG_STOP, SEG_RECV1, SEG_ADDR_R, SEG_START,
                                         SEG_REG1, SEG_ADDR_W, SEG_START};
    localparam logic [63:0] PAIR_SEQ  = {12'd0, SEG_STOP, SEG_RECV2, SEG_ADDR_R, SEG_START,
                                         SEG_REG2, SEG_ADDR_W, SEG_START,
                                         SEG_RECV1, SEG_ADDR_R, SEG_START,
                                         SEG_REG1, SEG_ADDR_W, SEG_START};

    // One pending input transaction plus how to steer its data line level
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] reg1;
        logic [7:0] reg2;
        logic [7:0] wdata;
        logic       sda;
        logic       steer;
        logic [7:0] want_first;
        logic [7:0] want_second;
        logic [6:0] nack_pct;
    } t_stim;

    // One result transaction
    typedef struct packed {
        logic             scl;
        logic             sda_rel;
        logic             busy;
        logic             done;
        logic             rejected;
        logic [7:0]       first;
        logic [7:0]       second;
        logic [2:0]       nacks;
        logic [LUX_W-1:0] lux;
    } t_bus_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [7:0]       i_cfg_data = 8'd0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [2:0]       i_op = OP_TICK;
    logic [7:0]       i_reg_addr = 8'd0;
    logic [7:0]       i_reg_addr_second = 8'd0;
    logic [7:0]       i_write_data = 8'd0;
    logic             i_sda_in = 1'b1;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_scl_level;
    logic             o_sda_release;
    logic             o_busy_res;
    logic             o_done_res;
    logic             o_rejected;
    logic [7:0]       o_read_first;
    logic [7:0]       o_read_second;
    logic [2:0]       o_nack_count;
    logic [LUX_W-1:0] o_lux_value;

    i2c_register_reader_with_lux_convert DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_reg_addr        (i_reg_addr),
        .i_reg_addr_second (i_reg_addr_second),
        .i_write_data      (i_write_data),
        .i_sda_in          (i_sda_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_scl_level       (o_scl_level),
        .o_sda_release     (o_sda_release),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_rejected        (o_rejected),
        .o_read_first      (o_read_first),
        .o_read_second     (o_read_second),
        .o_nack_count      (o_nack_count),
        .o_lux_value       (o_lux_value)
    );

    // Clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_stim       pending_items[$];
    t_bus_result expected_results[$];

    // Sequencer copy kept by the testbench
    logic [7:0]  dev_addr_byte = DEV_ADDR_RST;
    logic [5:0]  bus_step = STEP_IDLE;
    logic [3:0]  bus_bit = 4'd0;
    logic [7:0]  bus_shift = 8'd0;
    logic [2:0]  bus_kind = 3'd0;
    logic [23:0] bus_held = 24'd0;
    logic [15:0] bus_rx = 16'd0;
    logic [2:0]  bus_nacks = 3'd0;
    logic [1:0]  bit_phase = 2'd0;
    logic        bus_scl = 1'b1;
    logic        bus_sda = 1'b1;

    int  items_pushed = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  unexpected_count = 0;
    int  finished_count = 0;
    int  reject_count = 0;
    int  addr_writes = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  idle_enabled = 1'b0;
    bit  held_by_stall = 1'b0;

    t_stim       next_item;
    t_bus_result want_res;
    t_bus_result pred_res;

    function automatic logic [5:0] seq_length(input logic [2:0] kind);
        if (kind == OP_WRITE) return 6'd5;
        if (kind == OP_READ) return 6'd7;
        return 6'd13;
    endfunction

    function automatic logic [3:0] segment_at(input logic [2:0] kind, input logic [3:0] step);
        logic [63:0] order;
        if (kind == OP_WRITE) order = WRITE_SEQ;
        else if (kind == OP_READ) order = READ_SEQ;
        else order = PAIR_SEQ;
        return order[{step, 2'b00} +: 4];
    endfunction

    // Byte shifted out by a sending segment
    function automatic logic [7:0] send_byte(input logic [3:0] seg);
        case (seg)
            SEG_ADDR_W: return dev_addr_byte;
            SEG_ADDR_R: return dev_addr_byte + 8'd1;
            SEG_REG1:   return bus_held[7:0];
            SEG_REG2:   return bus_held[15:8];
            default:    return bus_held[23:16];
        endcase
    endfunction

    function automatic logic [LUX_W-1:0] light_value(input logic [7:0] hi, input logic [7:0] lo);
        logic [3:0]  ex;
        logic [31:0] scaled;
        ex = hi[7:4];
        if (ex == 4'd1) ex = 4'd0;
        else if (ex > LUX_EXP_MAX) ex = LUX_EXP_MAX;
        scaled = ({24'd0, hi[3:0], lo[3:0]} << ex) * LUX_SCALE;
        return scaled[LUX_W-1:0];
    endfunction

    task automatic next_segment();
        bus_step = bus_step + 6'd1;
        bus_bit = 4'd0;
        bit_phase = 2'd0;
        if (bus_step >= seq_length(bus_kind)) bus_step = STEP_IDLE;
    endtask

    // One bus phase of the running sequence
    task automatic run_bus_phase(input logic sda_in, output logic stop_done);
        logic [3:0] seg;
        logic       recv;
        stop_done = 1'b0;
        if (bus_step >= seq_length(bus_kind)) begin
            bus_step = STEP_IDLE;
            bus_scl = 1'b1;
            bus_sda = 1'b1;
        end else begin
            seg = segment_at(bus_kind, bus_step[3:0]);
            if (seg == SEG_START) begin
                bus_scl = (bit_phase == 2'd1 || bit_phase == 2'd2);
                bus_sda = (bit_phase <= 2'd1);
                if (bit_phase == 2'd3) next_segment();
                else bit_phase = bit_phase + 2'd1;
            end else if (seg == SEG_STOP) begin
                bus_scl = (bit_phase >= 2'd1);
                bus_sda = (bit_phase >= 2'd2);
                if (bit_phase >= 2'd2) begin
                    bus_step = STEP_IDLE;
                    bus_bit = 4'd0;
                    bit_phase = 2'd0;
                    stop_done = 1'b1;
                end else begin
                    bit_phase = bit_phase + 2'd1;
                end
            end else begin
                recv = (seg == SEG_RECV1 || seg == SEG_RECV2);
                if (bus_bit == 4'd0 && bit_phase == 2'd0) bus_shift = recv ? 8'h00 : send_byte(seg);
                bus_scl = (bit_phase != 2'd0);
                bus_sda = (bus_bit < 4'd8 && !recv) ? bus_shift[7] : 1'b1;
                if (bit_phase < 2'd2) begin
                    bit_phase = bit_phase + 2'd1;
                end else if (bus_bit < 4'd8) begin
                    // data line sampled on the last phase of the slot
                    bus_shift = {bus_shift[6:0], recv ? sda_in : 1'b0};
                    bus_bit = bus_bit + 4'd1;
                    bit_phase = 2'd0;
                end else begin
                    // ninth slot: store a received byte, or tally a NACK
                    if (seg == SEG_RECV1) bus_rx[7:0] = bus_shift;
                    else if (seg == SEG_RECV2) bus_rx[15:8] = bus_shift;
                    else if (sda_in && bus_nacks != 3'd7) bus_nacks = bus_nacks + 3'd1;
                    next_segment();
                end
            end
        end
    endtask

    // Expected result of one accepted input transaction
    task automatic predict_result(input logic [2:0] op, input logic [7:0] r1, input logic [7:0] r2,
                                  input logic [7:0] wd, input logic sda_in,
                                  output t_bus_result res);
        logic was_busy;
        logic stop_done;
        logic rej;
        was_busy = (bus_step != STEP_IDLE);
        stop_done = 1'b0;
        rej = 1'b0;
        if (op >= OP_WRITE && op <= OP_LUX) begin
            if (was_busy) begin
                rej = 1'b1;
            end else begin
                // command: latch operands, clear read bytes and NACK tally
                bus_kind = op;
                bus_held = (op == OP_LUX) ? {wd, LUX_REG_MANT, LUX_REG_EXP} : {wd, r2, r1};
                bus_rx = 16'd0;
                bus_nacks = 3'd0;
                bus_step = 6'd0;
                bus_bit = 4'd0;
                bit_phase = 2'd0;
                bus_shift = 8'd0;
                bus_scl = 1'b1;
                bus_sda = 1'b1;
            end
        end else if (was_busy) begin
            run_bus_phase(sda_in, stop_done);
        end else begin
            bus_scl = 1'b1;
            bus_sda = 1'b1;
        end
        res.scl = bus_scl;
        res.sda_rel = bus_sda;
        res.busy = (bus_step != STEP_IDLE);
        res.done = stop_done;
        res.rejected = rej;
        res.first = bus_rx[7:0];
        res.second = bus_rx[15:8];
        res.nacks = bus_nacks;
        res.lux = (bus_kind == OP_LUX) ? light_value(bus_rx[7:0], bus_rx[15:8]) : '0;
    endtask

    // Data line level for a tick: steered to the wanted bytes and NACK rate
    function automatic logic steer_sda(input t_stim it);
        logic [3:0] seg;
        logic       level;
        level = it.sda;
        if (it.steer && (it.op == OP_TICK || it.op > OP_LUX) &&
            bus_step < seq_length(bus_kind) && bit_phase == 2'd2) begin
            seg = segment_at(bus_kind, bus_step[3:0]);
            if (seg == SEG_RECV1 && bus_bit < 4'd8) begin
                level = it.want_first[3'd7 - bus_bit[2:0]];
            end else if (seg == SEG_RECV2 && bus_bit < 4'd8) begin
                level = it.want_second[3'd7 - bus_bit[2:0]];
            end else if (seg != SEG_START && seg != SEG_STOP && seg != SEG_RECV1 &&
                         seg != SEG_RECV2 && bus_bit == 4'd8) begin
                level = ($urandom_range(0, 99) < it.nack_pct);
            end
        end
        return level;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result check, then input acceptance and register write at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    if (unexpected_count < 10) $display("Unexpected result %0d", results_seen);
                    unexpected_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    compare_field("scl_level", 32'(want_res.scl), 32'(o_scl_level));
                    compare_field("sda_release", 32'(want_res.sda_rel), 32'(o_sda_release));
                    compare_field("busy_res", 32'(want_res.busy), 32'(o_busy_res));
                    compare_field("done_res", 32'(want_res.done), 32'(o_done_res));
                    compare_field("rejected", 32'(want_res.rejected), 32'(o_rejected));
                    compare_field("read_first", 32'(want_res.first), 32'(o_read_first));
                    compare_field("read_second", 32'(want_res.second), 32'(o_read_second));
                    compare_field("nack_count", 32'(want_res.nacks), 32'(o_nack_count));
                    compare_field("lux_value", 32'(want_res.lux), 32'(o_lux_value));
                end
                results_seen++;
            end
            if (i_cfg_we) dev_addr_byte = i_cfg_data;
            held_by_stall = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                predict_result(i_op, i_reg_addr, i_reg_addr_second, i_write_data, i_sda_in,
                               pred_res);
                if (pred_res.done) finished_count++;
                if (pred_res.rejected) reject_count++;
                expected_results.push_back(pred_res);
                items_accepted++;
            end
        end
    end

    // Input driver: holds a stalled transaction, otherwise idles or loads the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!held_by_stall) begin
            if (src_gap != 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 15) == 0) begin
                src_gap = $urandom_range(0, 12);
                i_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                i_op <= next_item.op;
                i_reg_addr <= next_item.reg1;
                i_reg_addr_second <= next_item.reg2;
                i_write_data <= next_item.wdata;
                i_sda_in <= steer_sda(next_item);
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side stall bursts
    always @(negedge i_clk) begin
        if (sink_gap != 0) begin
            sink_gap--;
            i_stall <= 1'b1;
        end else if (idle_enabled && $urandom_range(0, 15) == 0) begin
            sink_gap = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_item(input logic [2:0] op, input logic [7:0] r1, input logic [7:0] r2,
                             input logic [7:0] wd, input logic sda, input logic steer,
                             input logic [7:0] wf, input logic [7:0] ws,
                             input logic [6:0] pct);
        t_stim it;
        it.op = op;
        it.reg1 = r1;
        it.reg2 = r2;
        it.wdata = wd;
        it.sda = sda;
        it.steer = steer;
        it.want_first = wf;
        it.want_second = ws;
        it.nack_pct = pct;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic push_random_tick(input logic [2:0] op);
        push_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 8'd0, 8'd0, 7'd0);
    endtask

    task automatic issue_command(input logic [2:0] op, input logic [7:0] r1,
                                 input logic [7:0] r2, input logic [7:0] wd);
        push_item(op, r1, r2, wd, 1'($urandom_range(0, 1)), 1'b0, 8'd0, 8'd0, 7'd0);
    endtask

    // Ticks that walk a transaction; noisy runs mix in rejected commands
    // and unused op codes, which act as ticks
    task automatic issue_ticks(input int n, input logic steer, input logic [7:0] wf,
                               input logic [7:0] ws, input logic [6:0] pct, input bit noisy);
        logic [2:0] op;
        for (int t = 0; t < n; t++) begin
            if (noisy && $urandom_range(0, 39) == 0)
                push_random_tick(3'($urandom_range(OP_WRITE, OP_LUX)));
            op = (noisy && $urandom_range(0, 9) == 0) ?
                 3'($urandom_range(OP_SPARE_5, OP_SPARE_7)) : OP_TICK;
            push_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), steer, wf, ws, pct);
        end
    endtask

    function automatic int txn_ticks(input logic [2:0] op);
        if (op == OP_WRITE) return 88;
        if (op == OP_READ) return 119;
        return 235;
    endfunction

    // Wait for every result; optionally tick until the bus sequence is idle too
    task automatic wait_for_quiet(input bit to_idle);
        do begin
            @(negedge i_clk);
            while (items_accepted != items_pushed || expected_results.size() != 0)
                @(negedge i_clk);
            if (to_idle && bus_step != STEP_IDLE) push_random_tick(OP_TICK);
        end while (to_idle && bus_step != STEP_IDLE);
    endtask

    task automatic write_device_address(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        addr_writes++;
    endtask

    // Stimulus and end of run
    initial begin
        logic [2:0] op;
        logic [7:0] addr_setting;
        logic [6:0] pct;
        int         phase_items;
        int         leftover;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle: ticks and unused op codes leave the lines released
        push_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0);
        push_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'd0, 8'd0, 7'd0);
        push_item(OP_SPARE_5, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0);
        push_item(OP_SPARE_6, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 8'd0, 8'd0, 7'd0);
        push_item(OP_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'd0, 8'd0, 7'd0);

        // write with all ACKs; a command while busy and an op 7 tick mid-way
        issue_command(OP_WRITE, 8'hFF, 8'h00, 8'h00);
        issue_ticks(30, 1'b1, 8'd0, 8'd0, 7'd0, 1'b0);
        push_item(OP_READ2, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 7'd0);
        push_item(OP_SPARE_7, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd0, 8'd0, 7'd0);
        issue_ticks(57, 1'b1, 8'd0, 8'd0, 7'd0, 1'b0);

        // back-to-back write with every byte NACKed
        issue_command(OP_WRITE, 8'h00, 8'hFF, 8'hFF);
        issue_ticks(88, 1'b1, 8'd0, 8'd0, 7'd100, 1'b0);

        // single read, all NACKs, reads all ones
        issue_command(OP_READ, 8'h00, 8'hFF, 8'h00);
        issue_ticks(119, 1'b1, 8'hFF, 8'h00, 7'd100, 1'b0);

        // two-register read with an address change mid-transaction
        issue_command(OP_READ2, 8'h5A, 8'hFF, 8'h00);
        issue_ticks(40, 1'b1, 8'h00, 8'hA5, 7'd100, 1'b0);
        wait_for_quiet(1'b0);
        write_device_address(8'($urandom_range(0, 126) * 2 + 1));
        issue_ticks(195, 1'b1, 8'h00, 8'hA5, 7'd100, 1'b0);

        // light reads: exponent one, and above the clamp
        issue_command(OP_LUX, 8'h00, 8'h00, 8'h00);
        issue_ticks(235, 1'b1, 8'h1F, 8'h0F, 7'd0, 1'b0);
        issue_command(OP_LUX, 8'hFF, 8'hFF, 8'hFF);
        issue_ticks(235, 1'b1, 8'hFF, 8'hFF, 7'd50, 1'b0);
        wait_for_quiet(1'b1);

        // random phases, one address setting each; the last one runs without idling
        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       addr_setting = 8'd0;
                1:       addr_setting = 8'd254;
                default: addr_setting = DEV_ADDR_RST;
            endcase
            wait_for_quiet(1'b1);
            write_device_address(addr_setting);
            idle_enabled = (p != 2);
            phase_items = 0;
            while (phase_items < PHASE_QUOTA) begin
                repeat ($urandom_range(0, 2))
                    push_random_tick(($urandom_range(0, 1) == 0) ? OP_TICK :
                                     3'($urandom_range(OP_SPARE_5, OP_SPARE_7)));
                op = 3'($urandom_range(OP_WRITE, OP_LUX));
                case ($urandom_range(0, 3))
                    0:       pct = 7'd0;
                    1:       pct = 7'd5;
                    2:       pct = 7'd50;
                    default: pct = 7'd100;
                endcase
                issue_command(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                issue_ticks(txn_ticks(op), $urandom_range(0, 9) != 0,
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pct,
                            $urandom_range(0, 3) == 0);
                phase_items += txn_ticks(op);
            end
        end

        // drain, then wait for stray results before the final count
        idle_enabled = 1'b0;
        while (items_accepted != items_pushed) @(negedge i_clk);
        for (int k = 0; k < 2000 && expected_results.size() != 0; k++) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        leftover = expected_results.size();
        if (leftover != 0) $display("%0d expected results never arrived", leftover);

        $display("Sent %0d input transactions, checked %0d results", items_accepted, results_seen);
        $display("Bus sequences finished: %0d, commands rejected: %0d, address writes: %0d",
                 finished_count, reject_count, addr_writes);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("Timeout waiting for the run to finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
